// ===== hw/rtl/ihpc_pkg.sv =====
// Shared types and constants for the IPv4 header parse and checksum check block.
`timescale 1ns / 1ps

package ihpc_pkg;

  // result status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NOT_IP  = 3'd1;
  localparam logic [2:0] ST_BAD_HDR = 3'd2;
  localparam logic [2:0] ST_CSUM    = 3'd3;
  localparam logic [2:0] ST_TRUNC   = 3'd4;

  // Ethernet header is seven words; the last one is the EtherType
  localparam logic [5:0]  EthWords      = 6'd7;
  localparam logic [5:0]  EtherTypePos  = 6'd6;
  localparam logic [15:0] EtherTypeIpv4 = 16'h0800;
  localparam logic [3:0]  IpVersion     = 4'd4;
  localparam logic [3:0]  MinIhl        = 4'd5;

  // word index within the IPv4 header
  localparam logic [4:0] HdrVerIhl = 5'd0;
  localparam logic [4:0] HdrLength = 5'd1;
  localparam logic [4:0] HdrFrag   = 5'd3;
  localparam logic [4:0] HdrProto  = 5'd4;
  localparam logic [4:0] HdrSrcHi  = 5'd6;
  localparam logic [4:0] HdrSrcLo  = 5'd7;
  localparam logic [4:0] HdrDstHi  = 5'd8;
  localparam logic [4:0] HdrDstLo  = 5'd9;

  // queue between front and back; depth must be a power of two
  localparam int QueueDepth = 2;
  localparam int QueueAw    = $clog2(QueueDepth);

  typedef enum logic [1:0] {
    OP_HDR,   // header word: accumulate and capture
    OP_DONE,  // last header word: accumulate, capture, report header
    OP_ERR    // report err_status with zeroed fields
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [2:0]  err_status;
    logic [4:0]  hdr_idx;
    logic [15:0] word;
  } entry_t;

endpackage

// ===== hw/rtl/ihpc_front.sv =====
// Front end: tracks frame position, classifies each word and queues header work.
`timescale 1ns / 1ps

module ihpc_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [15:0]     frame_word_i,
  input  logic            frame_end_i,
  output logic            push_o,
  output ihpc_pkg::entry_t entry_o,
  input  logic            full_i
);
  import ihpc_pkg::*;

  logic [5:0] wp_q, wp_d;
  logic       skip_q, skip_d;
  logic [3:0] ihl_q, ihl_d;
  logic       accept;
  logic [5:0] k6;
  logic [3:0] ihl_eff;
  logic       finish, clear;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i & ~full_i;
  assign k6         = wp_q - EthWords;
  assign ihl_eff    = (k6 == 6'd0) ? frame_word_i[11:8] : ihl_q;

  always_comb begin
    wp_d    = wp_q;
    skip_d  = skip_q;
    ihl_d   = ihl_q;
    push_o  = 1'b0;
    finish  = 1'b0;
    clear   = 1'b0;
    entry_o = '{op: OP_HDR, err_status: ST_OK, hdr_idx: k6[4:0], word: frame_word_i};
    if (accept) begin
      if (skip_q) begin
        clear = frame_end_i;
      end else if (wp_q < EthWords) begin
        if (wp_q == EtherTypePos && frame_word_i != EtherTypeIpv4) begin
          push_o           = 1'b1;
          entry_o.op       = OP_ERR;
          entry_o.err_status = ST_NOT_IP;
          finish           = 1'b1;
        end else begin
          wp_d = wp_q + 6'd1;
          if (frame_end_i) begin
            push_o           = 1'b1;
            entry_o.op       = OP_ERR;
            entry_o.err_status = ST_TRUNC;
            clear            = 1'b1;
          end
        end
      end else if (k6 == 6'd0 &&
                   (frame_word_i[15:12] != IpVersion || frame_word_i[11:8] < MinIhl)) begin
        push_o           = 1'b1;
        entry_o.op       = OP_ERR;
        entry_o.err_status = ST_BAD_HDR;
        finish           = 1'b1;
      end else if (({1'b0, k6} + 7'd1) >= {2'b00, ihl_eff, 1'b0}) begin
        push_o     = 1'b1;
        entry_o.op = OP_DONE;
        ihl_d      = ihl_eff;
        finish     = 1'b1;
      end else begin
        push_o = 1'b1;
        wp_d   = wp_q + 6'd1;
        ihl_d  = ihl_eff;
        if (frame_end_i) begin
          // frame ran out inside the header
          entry_o.op       = OP_ERR;
          entry_o.err_status = ST_TRUNC;
          clear            = 1'b1;
        end
      end
      if (finish && frame_end_i) begin
        clear = 1'b1;
      end
    end
    if (clear) begin
      wp_d   = '0;
      skip_d = 1'b0;
      ihl_d  = '0;
    end else if (finish) begin
      skip_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      skip_q <= 1'b0;
      ihl_q  <= '0;
    end else begin
      wp_q   <= wp_d;
      skip_q <= skip_d;
      ihl_q  <= ihl_d;
    end
  end

endmodule

// ===== hw/rtl/ihpc_queue.sv =====
// Short request queue between the front end and the back end.
`timescale 1ns / 1ps

module ihpc_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  ihpc_pkg::entry_t entry_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output ihpc_pkg::entry_t entry_o
);
  import ihpc_pkg::*;

  entry_t             mem_q [QueueDepth];
  logic [QueueAw-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueueAw:0]   count_q;

  assign full_o  = (count_q == (QueueAw + 1)'(QueueDepth));
  assign valid_o = (count_q != '0);
  assign entry_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QueueAw'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QueueAw'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + (QueueAw + 1)'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - (QueueAw + 1)'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/ihpc_back.sv =====
// Back end: checksum accumulation, field capture and the result register.
`timescale 1ns / 1ps

module ihpc_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  ihpc_pkg::entry_t q_entry_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [2:0]       status_o,
  output logic [31:0]      source_address_o,
  output logic [31:0]      destination_address_o,
  output logic [7:0]       protocol_number_o,
  output logic [15:0]      total_length_o,
  output logic [15:0]      fragment_offset_o,
  output logic [3:0]       header_words_o,
  output logic [15:0]      checksum_residue_o
);
  import ihpc_pkg::*;

  logic [15:0] sum_q, sum_d;
  logic [3:0]  ihl_q, ihl_d;
  logic [15:0] len_q, len_d;
  logic [12:0] off_q, off_d;
  logic [7:0]  proto_q, proto_d;
  logic [31:0] src_q, src_d;
  logic [31:0] dst_q, dst_d;
  logic [15:0] sum_base;
  logic [16:0] sum_raw;
  logic [15:0] residue;
  logic        emits, load_ok, is_hdr, load;
  logic        out_valid_q;

  logic [2:0]  status_q;
  logic [31:0] src_out_q, dst_out_q;
  logic [7:0]  proto_out_q;
  logic [15:0] len_out_q, frag_out_q, residue_out_q;
  logic [3:0]  ihl_out_q;

  assign emits   = (q_entry_i.op != OP_HDR);
  assign is_hdr  = (q_entry_i.op != OP_ERR);
  assign load_ok = ~out_valid_q | ~out_stall_i;
  assign q_pop_o = q_valid_i & (~emits | load_ok);
  assign load    = q_pop_o & emits;

  // ones-complement add: a carry out wraps back in as +1
  assign sum_base = (q_entry_i.hdr_idx == HdrVerIhl) ? 16'd0 : sum_q;
  assign sum_raw  = {1'b0, sum_base} + {1'b0, q_entry_i.word};
  assign sum_d    = sum_raw[16] ? (sum_raw[15:0] + 16'd1) : sum_raw[15:0];
  assign residue  = ~sum_d;

  always_comb begin
    ihl_d   = ihl_q;
    len_d   = len_q;
    off_d   = off_q;
    proto_d = proto_q;
    src_d   = src_q;
    dst_d   = dst_q;
    case (q_entry_i.hdr_idx)
      HdrVerIhl: ihl_d         = q_entry_i.word[11:8];
      HdrLength: len_d         = q_entry_i.word;
      HdrFrag:   off_d         = q_entry_i.word[12:0];
      HdrProto:  proto_d       = q_entry_i.word[7:0];
      HdrSrcHi:  src_d[31:16]  = q_entry_i.word;
      HdrSrcLo:  src_d[15:0]   = q_entry_i.word;
      HdrDstHi:  dst_d[31:16]  = q_entry_i.word;
      HdrDstLo:  dst_d[15:0]   = q_entry_i.word;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o && is_hdr) begin
      sum_q   <= sum_d;
      ihl_q   <= ihl_d;
      len_q   <= len_d;
      off_q   <= off_d;
      proto_q <= proto_d;
      src_q   <= src_d;
      dst_q   <= dst_d;
    end
    if (load) begin
      if (is_hdr) begin
        status_q      <= (residue == 16'd0) ? ST_OK : ST_CSUM;
        src_out_q     <= src_d;
        dst_out_q     <= dst_d;
        proto_out_q   <= proto_d;
        len_out_q     <= len_d;
        frag_out_q    <= {off_d, 3'b000};
        ihl_out_q     <= ihl_d;
        residue_out_q <= residue;
      end else begin
        status_q      <= q_entry_i.err_status;
        src_out_q     <= '0;
        dst_out_q     <= '0;
        proto_out_q   <= '0;
        len_out_q     <= '0;
        frag_out_q    <= '0;
        ihl_out_q     <= '0;
        residue_out_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign status_o              = status_q;
  assign source_address_o      = src_out_q;
  assign destination_address_o = dst_out_q;
  assign protocol_number_o     = proto_out_q;
  assign total_length_o        = len_out_q;
  assign fragment_offset_o     = frag_out_q;
  assign header_words_o        = ihl_out_q;
  assign checksum_residue_o    = residue_out_q;

endmodule

// ===== hw/rtl/ipv4_header_parse_check.sv =====
// IPv4 header parse and checksum check: top level.
//
// Input channel: one 16-bit frame word per request (first byte in bits 15:8),
// frame_end_i marks the last word of a frame. Ethernet header is words 0..6,
// word 6 must be EtherType 0x0800; the IPv4 header follows.
// Output channel: one result per frame (status plus captured header fields),
// given when the header completes, on an error, or when the frame ends early.
// Words after the result are dropped up to the end mark.
// Throughput: one word per cycle while in_stall_o is low; the checksum is a single
// 16-bit end-around-carry add per word in the back end.
// Path: the deciding word is written into the two-entry queue when it is
// accepted, and the result register is loaded from the queue head once that
// register is empty or its result is being taken.
// Reset: parsing starts at word 0 of a new frame, queue and result empty.
// Stall: a shown result holds while out_stall_i is high; the next result
// request then waits at the head of the queue, words behind it collect, and
// in_stall_o rises once the queue is full.
`timescale 1ns / 1ps

module ipv4_header_parse_check (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] frame_word_i,
  input  logic        frame_end_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [31:0] source_address_o,
  output logic [31:0] destination_address_o,
  output logic [7:0]  protocol_number_o,
  output logic [15:0] total_length_o,
  output logic [15:0] fragment_offset_o,
  output logic [3:0]  header_words_o,
  output logic [15:0] checksum_residue_o
);
  import ihpc_pkg::*;

  logic   push, full, pop, q_valid;
  entry_t push_entry, pop_entry;

  ihpc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .frame_word_i (frame_word_i),
    .frame_end_i  (frame_end_i),
    .push_o       (push),
    .entry_o      (push_entry),
    .full_i       (full)
  );

  ihpc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .entry_o (pop_entry)
  );

  ihpc_back u_back (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .q_valid_i             (q_valid),
    .q_entry_i             (pop_entry),
    .q_pop_o               (pop),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .status_o              (status_o),
    .source_address_o      (source_address_o),
    .destination_address_o (destination_address_o),
    .protocol_number_o     (protocol_number_o),
    .total_length_o        (total_length_o),
    .fragment_offset_o     (fragment_offset_o),
    .header_words_o        (header_words_o),
    .checksum_residue_o    (checksum_residue_o)
  );

  // status agrees with the residue it carries
  a_ok_residue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_OK |-> checksum_residue_o == 16'd0)
    else $error("ok result with nonzero residue");

  a_csum_residue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_CSUM |-> checksum_residue_o != 16'd0)
    else $error("checksum error with zero residue");

  // header results always carry a legal IHL
  a_hdr_ihl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_OK || status_o == ST_CSUM) |-> header_words_o >= MinIhl)
    else $error("header result with IHL below minimum");

  // error results have all fields cleared; addresses, IHL and residue are checked
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_NOT_IP || status_o == ST_BAD_HDR || status_o == ST_TRUNC)
    |-> source_address_o == 32'd0 && destination_address_o == 32'd0 &&
        header_words_o == 4'd0 && checksum_residue_o == 16'd0)
    else $error("error result with nonzero fields");

  // a result shown under stall must not vanish, nor change its status or residue
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) &&
                                   $stable(checksum_residue_o))
    else $error("stalled result changed");

endmodule

// ===== verif/tb_ipv4_header_parse_check.sv =====
// Self-checking testbench for the IPv4 header parse and checksum check block.
`timescale 1ns / 1ps

module tb_ipv4_header_parse_check;
  import ihpc_pkg::*;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] source_address;
    logic [31:0] destination_address;
    logic [7:0]  protocol_number;
    logic [15:0] total_length;
    logic [15:0] fragment_offset;
    logic [3:0]  header_words;
    logic [15:0] checksum_residue;
  } hdr_result_t;

  typedef struct {
    logic [15:0] word;
    logic        last;
    bit          typed;   // expected result given in the row, not by the predictor
    hdr_result_t want;
  } stim_item_t;

  typedef enum {FR_NOISE, FR_BAD_ETYPE, FR_BAD_HDR, FR_SHORT, FR_GOOD} frame_kind_e;

  localparam int DirRows     = 26;
  localparam int RandWords   = 850;
  localparam int HoldCycles  = 300;
  localparam int DrainCycles = 16;
  // longest quiet stretch in a correct run is the output hold-off; allow several times it
  localparam int QuietLimit  = 2000;

  localparam hdr_result_t NoRes    = '0;
  localparam hdr_result_t TruncRes = '{status: ST_TRUNC, default: '0};
  localparam hdr_result_t NotIpRes = '{status: ST_NOT_IP, default: '0};
  localparam hdr_result_t BcastOk  = '{status: ST_OK, source_address: 32'hFFFF_FFFF,
                                       destination_address: 32'h0, protocol_number: 8'hFF,
                                       total_length: 16'hFFFF, fragment_offset: 16'hFFF8,
                                       header_words: 4'd5, checksum_residue: 16'h0};

  stim_item_t dir_tbl [DirRows] = '{
    '{16'hFFFF, 1'b1, 1'b1, TruncRes},
    '{16'hFFFF, 1'b0, 1'b0, NoRes},
    '{16'hFFFF, 1'b0, 1'b0, NoRes},
    '{16'hFFFF, 1'b0, 1'b0, NoRes},
    '{16'h0000, 1'b0, 1'b0, NoRes},
    '{16'h0000, 1'b0, 1'b0, NoRes},
    '{16'h0000, 1'b0, 1'b0, NoRes},
    '{16'h86DD, 1'b0, 1'b1, NotIpRes},
    '{16'h1234, 1'b1, 1'b0, NoRes},     // dropped; its end mark restarts parsing
    '{16'h0123, 1'b0, 1'b0, NoRes},
    '{16'h4567, 1'b0, 1'b0, NoRes},
    '{16'h89AB, 1'b0, 1'b0, NoRes},
    '{16'hCDEF, 1'b0, 1'b0, NoRes},
    '{16'hFEDC, 1'b0, 1'b0, NoRes},
    '{16'hBA98, 1'b0, 1'b0, NoRes},
    '{16'h0800, 1'b0, 1'b0, NoRes},
    '{16'h4500, 1'b0, 1'b0, NoRes},
    '{16'hFFFF, 1'b0, 1'b0, NoRes},
    '{16'h0000, 1'b0, 1'b0, NoRes},
    '{16'hFFFF, 1'b0, 1'b0, NoRes},
    '{16'hFFFF, 1'b0, 1'b0, NoRes},
    '{16'hBAFF, 1'b0, 1'b0, NoRes},     // makes the header sum all ones
    '{16'hFFFF, 1'b0, 1'b0, NoRes},
    '{16'hFFFF, 1'b0, 1'b0, NoRes},
    '{16'h0000, 1'b0, 1'b0, NoRes},
    '{16'h0000, 1'b1, 1'b1, BcastOk}    // header completes on the end mark
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [15:0] frame_word_i = '0;
  logic        frame_end_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  status_o;
  logic [31:0] source_address_o;
  logic [31:0] destination_address_o;
  logic [7:0]  protocol_number_o;
  logic [15:0] total_length_o;
  logic [15:0] fragment_offset_o;
  logic [3:0]  header_words_o;
  logic [15:0] checksum_residue_o;

  ipv4_header_parse_check dut (.*);

  always #6 clk_i = ~clk_i;

  stim_item_t  word_q[$];
  hdr_result_t pending[$];
  bit          cur_typed = 1'b0;
  hdr_result_t cur_want = '0;
  int          in_idle_pct = 31;
  int          out_idle_pct = 59;
  int          words_taken = 0;
  int          results_taken = 0;
  int          mismatches = 0;
  int          status_cnt [8];
  int          hold_at = 32'h7FFF_FFFF;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  int          quiet = 0;

  // parser state as seen by the predictor
  logic [5:0]  wpos = '0;
  bit          in_skip = 1'b0;
  logic [15:0] csum_acc = '0;
  logic [3:0]  ihl_cap = '0;
  logic [31:0] src_cap = '0;
  logic [31:0] dst_cap = '0;
  logic [7:0]  proto_cap = '0;
  logic [15:0] len_cap = '0;
  logic [12:0] frag_cap = '0;

  function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s > 17'h0FFFF) s = s - 17'h0FFFF;
    return s[15:0];
  endfunction

  function automatic void restart_frame();
    wpos = '0;
    in_skip = 1'b0;
    csum_acc = '0;
    ihl_cap = '0;
    src_cap = '0;
    dst_cap = '0;
    proto_cap = '0;
    len_cap = '0;
    frag_cap = '0;
  endfunction

  // after the frame's one result: drop words until the end mark
  function automatic void close_frame(input logic last);
    if (last) restart_frame();
    else in_skip = 1'b1;
  endfunction

  function automatic bit predict_word(input logic [15:0] w, input logic last,
                                      output hdr_result_t r);
    int          k;
    logic [15:0] residue;
    r = '0;
    if (in_skip) begin
      if (last) restart_frame();
      return 1'b0;
    end
    if (wpos < EthWords) begin
      if (wpos == EtherTypePos && w != EtherTypeIpv4) begin
        r.status = ST_NOT_IP;
        close_frame(last);
        return 1'b1;
      end
      wpos = wpos + 6'd1;
      if (last) begin
        r.status = ST_TRUNC;
        restart_frame();
        return 1'b1;
      end
      return 1'b0;
    end
    k = int'(wpos - EthWords);
    case (k)
      HdrVerIhl: begin
        ihl_cap = w[11:8];
        if (w[15:12] != IpVersion || w[11:8] < MinIhl) begin
          r.status = ST_BAD_HDR;
          close_frame(last);
          return 1'b1;
        end
      end
      HdrLength: len_cap = w;
      HdrFrag:   frag_cap = w[12:0];   // network order, no byte swap
      HdrProto:  proto_cap = w[7:0];
      HdrSrcHi:  src_cap[31:16] = w;
      HdrSrcLo:  src_cap[15:0] = w;
      HdrDstHi:  dst_cap[31:16] = w;
      HdrDstLo:  dst_cap[15:0] = w;
      default: ;
    endcase
    csum_acc = ones_add(csum_acc, w);
    if (k + 1 >= 2 * int'(ihl_cap)) begin
      residue = ~csum_acc;
      r = '{status: (residue == 16'h0) ? ST_OK : ST_CSUM, source_address: src_cap,
            destination_address: dst_cap, protocol_number: proto_cap,
            total_length: len_cap, fragment_offset: {frag_cap, 3'b000},
            header_words: ihl_cap, checksum_residue: residue};
      close_frame(last);
      return 1'b1;
    end
    wpos = wpos + 6'd1;
    if (last) begin
      r.status = ST_TRUNC;
      restart_frame();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic string fmt_result(input hdr_result_t r);
    return $sformatf("st=%0d src=%h dst=%h proto=%h len=%h frag=%h ihl=%0d res=%h",
                     r.status, r.source_address, r.destination_address, r.protocol_number,
                     r.total_length, r.fragment_offset, r.header_words, r.checksum_residue);
  endfunction

  function automatic void flag_error(input string msg);
    if (mismatches < 10) $display("%s", msg);
    mismatches++;
  endfunction

  // One frame: mostly well-formed headers with random content, plus noise,
  // bad EtherType, bad version/IHL and early ends.
  task automatic add_random_frame();
    logic [15:0] fw[$];
    logic [15:0] hdr [30];
    frame_kind_e kind;
    int          pick, ihl, hdr_n, d, e;
    logic [15:0] acc;
    pick = $urandom_range(99);
    kind = pick < 12 ? FR_NOISE : pick < 22 ? FR_BAD_ETYPE : pick < 32 ? FR_BAD_HDR :
           pick < 42 ? FR_SHORT : FR_GOOD;
    if (kind == FR_NOISE) begin
      repeat ($urandom_range(24, 1)) fw.push_back(16'($urandom));
      e = fw.size() - 1;
    end else begin
      repeat (6) fw.push_back(16'($urandom));
      if (kind != FR_BAD_ETYPE) fw.push_back(EtherTypeIpv4);
      else if ($urandom_range(1)) fw.push_back(EtherTypeIpv4 ^ (16'h1 << $urandom_range(15)));
      else fw.push_back(16'($urandom));
      ihl = ($urandom_range(9) == 0) ? $urandom_range(15, 7) : $urandom_range(6, 5);
      hdr_n = 2 * ihl;
      for (int i = 0; i < hdr_n; i++) hdr[i] = 16'($urandom);
      hdr[0] = {IpVersion, 4'(ihl), hdr[0][7:0]};
      if (kind == FR_BAD_HDR) begin
        if ($urandom_range(1)) hdr[0][15:12] = 4'(IpVersion + 4'($urandom_range(15, 1)));
        else hdr[0][11:8] = 4'($urandom_range(4));
      end
      if ($urandom_range(9) < 7) begin
        hdr[5] = '0;
        acc = '0;
        for (int i = 0; i < hdr_n; i++) acc = ones_add(acc, hdr[i]);
        hdr[5] = ~acc;
      end
      for (int i = 0; i < hdr_n; i++) fw.push_back(hdr[i]);
      d = (kind == FR_BAD_ETYPE) ? EtherTypePos : (kind == FR_BAD_HDR) ? EthWords
                                                : EthWords + hdr_n - 1;
      e = (kind == FR_SHORT) ? $urandom_range(d - 1) : d + $urandom_range(3);
    end
    while (fw.size() <= e) fw.push_back(16'($urandom));
    for (int i = 0; i <= e; i++) word_q.push_back('{fw[i], i == e, 1'b0, NoRes});
  endtask

  // request side
  always @(posedge clk_i or negedge rst_ni) begin : sender
    stim_item_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      frame_word_i <= '0;
      frame_end_i <= 1'b0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (word_q.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
        nxt = word_q.pop_front();
        in_valid_i <= 1'b1;
        frame_word_i <= nxt.word;
        frame_end_i <= nxt.last;
        cur_typed <= nxt.typed;
        cur_want <= nxt.want;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result side stall, with one long hold-off late in the run
  always @(posedge clk_i or negedge rst_ni) begin : receiver
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (!hold_done && words_taken >= hold_at) begin
      hold_left <= HoldCycles - 1;
      hold_done <= 1'b1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < out_idle_pct);
    end
  end

  always @(posedge clk_i) begin : scoreboard
    hdr_result_t pred, got;
    bit          hit;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        hit = predict_word(frame_word_i, frame_end_i, pred);
        if (cur_typed) pending.push_back(cur_want);
        else if (hit) pending.push_back(pred);
        words_taken <= words_taken + 1;
      end
      if (out_valid_o && !out_stall_i) begin
        got = '{status: status_o, source_address: source_address_o,
                destination_address: destination_address_o,
                protocol_number: protocol_number_o, total_length: total_length_o,
                fragment_offset: fragment_offset_o, header_words: header_words_o,
                checksum_residue: checksum_residue_o};
        results_taken <= results_taken + 1;
        status_cnt[got.status]++;
        if (pending.size() == 0) begin
          flag_error($sformatf("[%0t] unexpected result: %s", $realtime, fmt_result(got)));
        end else begin
          pred = pending.pop_front();
          if (got !== pred)
            flag_error($sformatf("[%0t] result mismatch\n  expected %s\n  actual   %s",
                                 $realtime, fmt_result(pred), fmt_result(got)));
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet <= 0;
    end else if (quiet >= QuietLimit) begin
      $display("ipv4_header_parse_check verification failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin : control
    int n_items;
    foreach (dir_tbl[i]) word_q.push_back(dir_tbl[i]);
    while (word_q.size() < DirRows + RandWords) add_random_frame();
    n_items = word_q.size();
    hold_at = n_items * 5 / 6;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (words_taken < n_items / 3) @(posedge clk_i);
    in_idle_pct <= 59;
    out_idle_pct <= 31;
    while (words_taken < 2 * n_items / 3) @(posedge clk_i);
    in_idle_pct <= 0;
    out_idle_pct <= 0;
    while (words_taken < n_items || pending.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (pending.size() != 0) begin
      $display("%0d expected results never arrived, oldest %s", pending.size(),
               fmt_result(pending[0]));
      mismatches += pending.size();
    end
    $display("Run: %0d frame words, %0d results (ok %0d, not IPv4 %0d, bad header %0d,",
             words_taken, results_taken, status_cnt[ST_OK], status_cnt[ST_NOT_IP],
             status_cnt[ST_BAD_HDR]);
    $display("  checksum error %0d, truncated %0d); idling swapped, %0d-cycle output hold",
             status_cnt[ST_CSUM], status_cnt[ST_TRUNC], HoldCycles);
    if (mismatches == 0) begin
      $display("ipv4_header_parse_check verification clean");
    end else begin
      $display("ipv4_header_parse_check verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/ihpc_pkg.sv
hw/rtl/ihpc_front.sv
hw/rtl/ihpc_queue.sv
hw/rtl/ihpc_back.sv
hw/rtl/ipv4_header_parse_check.sv
verif/tb_ipv4_header_parse_check.sv
